>>> hw/rtl/fresnel_dielectric_reflectance_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the fresnel reflectance block
// Clocked concurrent checks, disabled while reset is asserted.
// ------------------------------------------------------------------------
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_MACROS_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_MACROS_SVH

// same-cycle implication
`define FDR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fdr_pkg.sv
// ------------------------------------------------------------------------
// fdr_pkg
// Stage map, constants and the pipeline stage record of the reflectance block.
// ------------------------------------------------------------------------
`default_nettype none

package fdr_pkg;

    localparam int unsigned SQ_STEPS  = 15;   // root bits of a Q14 sqrt
    localparam int unsigned DIV_STEPS = 14;   // transmitted sine bits
    localparam int unsigned RAT_STEPS = 16;   // ratio fraction bits

    // stage indices
    localparam int unsigned ST_IN    = 0;
    localparam int unsigned ST_SQ1_F = ST_IN + 1;
    localparam int unsigned ST_SQ1_L = ST_SQ1_F + SQ_STEPS - 1;
    localparam int unsigned ST_SNELL = ST_SQ1_L + 1;
    localparam int unsigned ST_DIV_F = ST_SNELL + 1;
    localparam int unsigned ST_DIV_L = ST_DIV_F + DIV_STEPS - 1;
    localparam int unsigned ST_STSQ  = ST_DIV_L + 1;
    localparam int unsigned ST_SQ2_F = ST_STSQ + 1;
    localparam int unsigned ST_SQ2_L = ST_SQ2_F + SQ_STEPS - 1;
    localparam int unsigned ST_PROD  = ST_SQ2_L + 1;
    localparam int unsigned ST_SUMD  = ST_PROD + 1;
    localparam int unsigned ST_QTOP  = ST_SUMD + 1;
    localparam int unsigned ST_RAT_F = ST_QTOP + 1;
    localparam int unsigned ST_RAT_L = ST_RAT_F + RAT_STEPS - 1;
    localparam int unsigned ST_QSQ   = ST_RAT_L + 1;
    localparam int unsigned ST_OUT   = ST_QSQ + 1;
    localparam int unsigned NSTG     = ST_OUT + 1;

    localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
    localparam logic signed [15:0] MONE_Q14   = -16'sd16384;
    localparam logic [15:0]        ONE_Q15    = 16'h8000;
    localparam logic [30:0]        ONE_SQ_Q28 = 31'h1000_0000;
    localparam logic [33:0]        HALF_Q32   = 34'h0_0001_0000;

    localparam int unsigned LANE_PAR  = 0;
    localparam int unsigned LANE_PERP = 1;

    typedef struct packed {
        logic [14:0]        ci;
        logic [15:0]        ei;
        logic [15:0]        et;
        logic               tir;
        logic [30:0]        srem;
        logic [14:0]        root;
        logic [31:0]        num;
        logic [13:0]        st;
        logic [1:0][30:0]   la;
        logic [1:0][30:0]   lb;
        logic [1:0][31:0]   ld;
        logic [1:0][32:0]   lrem;
        logic [1:0]         ldz;
        logic [1:0][16:0]   lq;
        logic [1:0][33:0]   lprod;
        logic [15:0]        refl;
    } t_stage;

endpackage

`default_nettype wire

>>> hw/rtl/fresnel_dielectric_reflectance.sv
// ------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized Fresnel reflectance of a dielectric boundary, fixed point.
// ------------------------------------------------------------------------
// Usage:
//   Input stream: one transfer carries the incident cosine (Q2.14, signed)
//   and both refractive indices (Q4.12). Output stream: one transfer per
//   input with the reflectance (Q1.15, 0x8000 = 1.0) in tdata and the total
//   internal reflection flag in tuser.
//   One item may enter every cycle; throughput is one item per cycle while
//   the receiver takes results. The pipeline is made of two bit-per-stage
//   square roots (15 stages each), a 14-stage restoring divider for the
//   transmitted sine and two parallel 17-stage ratio dividers, plus multiply
//   stages. The whole pipeline advances together: when the output register
//   holds a result the receiver has not taken, every stage freezes and
//   s_axis_tready drops, so nothing is lost or repeated.
//   Reset (synchronous, active low) clears all stage valid bits; the data
//   path holds no reset.
// ------------------------------------------------------------------------
`default_nettype none

`include "fresnel_dielectric_reflectance_macros.svh"

module fresnel_dielectric_reflectance (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [15:0] cos_incident, [31:16] eta_incident, [47:32] eta_transmitted
    input  wire logic [47:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] reflectance
    output logic [15:0]      o_m_axis_tdata,
    // [0] total_internal
    output logic [0:0]       o_m_axis_tuser
);

    localparam int unsigned NSTG = fdr_pkg::NSTG;

    fdr_pkg::t_stage r_pl [NSTG];
    fdr_pkg::t_stage n_pl [NSTG];
    logic [NSTG-1:0] r_vld;
    logic            w_en;

    // global advance: output slot empty or being taken
    assign w_en            = !r_vld[NSTG-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---- stage 0: clamp, side swap, |cos|, 1 - cos^2 ----
    always_comb begin
        logic signed [15:0] cc;
        logic signed [15:0] ca;
        logic [29:0]        cisq;
        n_pl[0] = '0;
        cc = $signed(i_s_axis_tdata[15:0]);
        if (cc > fdr_pkg::ONE_Q14) begin
            cc = fdr_pkg::ONE_Q14;
        end else if (cc < fdr_pkg::MONE_Q14) begin
            cc = fdr_pkg::MONE_Q14;
        end
        // ray from the other side when cos <= 0
        if (cc <= 16'sd0) begin
            n_pl[0].ei = i_s_axis_tdata[47:32];
            n_pl[0].et = i_s_axis_tdata[31:16];
        end else begin
            n_pl[0].ei = i_s_axis_tdata[31:16];
            n_pl[0].et = i_s_axis_tdata[47:32];
        end
        ca = cc[15] ? -cc : cc;
        n_pl[0].ci   = ca[14:0];
        cisq         = n_pl[0].ci * n_pl[0].ci;
        n_pl[0].srem = fdr_pkg::ONE_SQ_Q28 - {1'b0, cisq};
        n_pl[0].root = '0;
    end

    for (genvar s = 1; s < NSTG; s++) begin : g_stg
        if (s >= fdr_pkg::ST_SQ1_F && s <= fdr_pkg::ST_SQ1_L) begin : g_sq1
            // incident sine, one root bit per stage
            localparam int unsigned K = fdr_pkg::ST_SQ1_L - s;
            always_comb begin
                logic [30:0] trial;
                n_pl[s] = r_pl[s-1];
                trial = ({16'd0, r_pl[s-1].root} << (K + 1)) + (31'd1 << (2 * K));
                if (r_pl[s-1].srem >= trial) begin
                    n_pl[s].srem    = r_pl[s-1].srem - trial;
                    n_pl[s].root[K] = 1'b1;
                end
            end
        end else if (s == fdr_pkg::ST_SNELL) begin : g_snell
            // ei*si and the saturation test against et*2^14
            always_comb begin
                logic [30:0] prod;
                n_pl[s] = r_pl[s-1];
                prod = r_pl[s-1].ei * r_pl[s-1].root;
                n_pl[s].num = {1'b0, prod};
                n_pl[s].tir = ({1'b0, prod} >= {2'b00, r_pl[s-1].et, 14'd0});
                n_pl[s].st  = '0;
            end
        end else if (s >= fdr_pkg::ST_DIV_F && s <= fdr_pkg::ST_DIV_L) begin : g_div
            // transmitted sine, restoring division
            localparam int unsigned K = fdr_pkg::ST_DIV_L - s;
            always_comb begin
                logic [31:0] dsh;
                n_pl[s] = r_pl[s-1];
                dsh = {16'd0, r_pl[s-1].et} << K;
                if (r_pl[s-1].num >= dsh) begin
                    n_pl[s].num   = r_pl[s-1].num - dsh;
                    n_pl[s].st[K] = 1'b1;
                end
            end
        end else if (s == fdr_pkg::ST_STSQ) begin : g_stsq
            always_comb begin
                logic [27:0] stsq;
                n_pl[s] = r_pl[s-1];
                stsq = r_pl[s-1].st * r_pl[s-1].st;
                n_pl[s].srem = fdr_pkg::ONE_SQ_Q28 - {3'b000, stsq};
                n_pl[s].root = '0;
            end
        end else if (s >= fdr_pkg::ST_SQ2_F && s <= fdr_pkg::ST_SQ2_L) begin : g_sq2
            // transmitted cosine
            localparam int unsigned K = fdr_pkg::ST_SQ2_L - s;
            always_comb begin
                logic [30:0] trial;
                n_pl[s] = r_pl[s-1];
                trial = ({16'd0, r_pl[s-1].root} << (K + 1)) + (31'd1 << (2 * K));
                if (r_pl[s-1].srem >= trial) begin
                    n_pl[s].srem    = r_pl[s-1].srem - trial;
                    n_pl[s].root[K] = 1'b1;
                end
            end
        end else if (s == fdr_pkg::ST_PROD) begin : g_prod
            // amplitude ratio terms; root is now the transmitted cosine
            always_comb begin
                n_pl[s] = r_pl[s-1];
                n_pl[s].la[fdr_pkg::LANE_PAR]  = r_pl[s-1].et * r_pl[s-1].ci;
                n_pl[s].lb[fdr_pkg::LANE_PAR]  = r_pl[s-1].ei * r_pl[s-1].root;
                n_pl[s].la[fdr_pkg::LANE_PERP] = r_pl[s-1].ei * r_pl[s-1].ci;
                n_pl[s].lb[fdr_pkg::LANE_PERP] = r_pl[s-1].et * r_pl[s-1].root;
            end
        end else if (s == fdr_pkg::ST_SUMD) begin : g_sumd
            always_comb begin
                n_pl[s] = r_pl[s-1];
                for (int l = 0; l < 2; l++) begin
                    n_pl[s].ld[l] = {1'b0, r_pl[s-1].la[l]} + {1'b0, r_pl[s-1].lb[l]};
                    if (r_pl[s-1].la[l] >= r_pl[s-1].lb[l]) begin
                        n_pl[s].lrem[l] = {2'b00, r_pl[s-1].la[l] - r_pl[s-1].lb[l]};
                    end else begin
                        n_pl[s].lrem[l] = {2'b00, r_pl[s-1].lb[l] - r_pl[s-1].la[l]};
                    end
                end
            end
        end else if (s == fdr_pkg::ST_QTOP) begin : g_qtop
            // integer bit of the ratio (set only when |n| == d)
            always_comb begin
                n_pl[s] = r_pl[s-1];
                for (int l = 0; l < 2; l++) begin
                    n_pl[s].ldz[l] = (r_pl[s-1].ld[l] == 32'd0);
                    n_pl[s].lq[l]  = '0;
                    if (r_pl[s-1].lrem[l] >= {1'b0, r_pl[s-1].ld[l]}) begin
                        n_pl[s].lrem[l]   = r_pl[s-1].lrem[l] - {1'b0, r_pl[s-1].ld[l]};
                        n_pl[s].lq[l][16] = 1'b1;
                    end
                end
            end
        end else if (s >= fdr_pkg::ST_RAT_F && s <= fdr_pkg::ST_RAT_L) begin : g_rat
            // fraction bits, shift-and-subtract long division
            localparam int unsigned K = fdr_pkg::ST_RAT_L - s;
            always_comb begin
                logic [32:0] r2;
                n_pl[s] = r_pl[s-1];
                for (int l = 0; l < 2; l++) begin
                    r2 = {r_pl[s-1].lrem[l][31:0], 1'b0};
                    if (r2 >= {1'b0, r_pl[s-1].ld[l]}) begin
                        n_pl[s].lrem[l]  = r2 - {1'b0, r_pl[s-1].ld[l]};
                        n_pl[s].lq[l][K] = 1'b1;
                    end else begin
                        n_pl[s].lrem[l] = r2;
                    end
                end
            end
        end else if (s == fdr_pkg::ST_QSQ) begin : g_qsq
            always_comb begin
                n_pl[s] = r_pl[s-1];
                for (int l = 0; l < 2; l++) begin
                    n_pl[s].lprod[l] = r_pl[s-1].lq[l] * r_pl[s-1].lq[l];
                end
            end
        end else begin : g_out
            // round each square to Q15, average half up; TIR forces 1.0
            always_comb begin
                logic [33:0] rs;
                logic [16:0] sq [2];
                logic [17:0] tot;
                n_pl[s] = r_pl[s-1];
                for (int l = 0; l < 2; l++) begin
                    rs    = r_pl[s-1].lprod[l] + fdr_pkg::HALF_Q32;
                    sq[l] = r_pl[s-1].ldz[l] ? {1'b0, fdr_pkg::ONE_Q15} : rs[33:17];
                end
                tot = {1'b0, sq[0]} + {1'b0, sq[1]} + 18'd1;
                n_pl[s].refl = r_pl[s-1].tir ? fdr_pkg::ONE_Q15 : tot[16:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NSTG; s++) begin
                r_pl[s] <= n_pl[s];
            end
        end
    end

    assign o_m_axis_tvalid   = r_vld[NSTG-1];
    assign o_m_axis_tdata    = r_pl[NSTG-1].refl;
    assign o_m_axis_tuser[0] = r_pl[NSTG-1].tir;

    // ---- checks ----
    `FDR_ASSERT_IMPL(a_tir_is_one, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == fdr_pkg::ONE_Q15, "TIR result not 1.0")
    `FDR_ASSERT_IMPL(a_refl_range, o_m_axis_tvalid, o_m_axis_tdata <= fdr_pkg::ONE_Q15, "reflectance above 1.0")
    `FDR_ASSERT_NEXT(a_accept_lands, i_s_axis_tvalid && o_s_axis_tready, r_vld[0], "accepted transfer lost at stage 0")
    `FDR_ASSERT_NEXT(a_stall_holds, o_m_axis_tvalid && !i_m_axis_tready, r_vld == $past(r_vld), "pipeline moved while stalled")

endmodule

`default_nettype wire
